// ----- sv/prbf_pkg.sv -----
// Package for the packet ring byte FIFO: word types, command and status codes,
// controller states and parameter defaults.
// No dependencies; the top level and the checker use it.
`timescale 1ns / 1ps
`default_nettype none

package prbf_pkg;

  // Parameter defaults.
  localparam int BUF_SIZE_DEF     = 32768;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_READ_DEF     = 64;

  // Command codes.
  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_SKIP   = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_STATUS = 3'd4;

  // Status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_SPACE = 2'd1;
  localparam logic [1:0] STS_EMPTY    = 2'd2;
  localparam logic [1:0] STS_DISABLED = 2'd3;

  // Input word.
  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic        packet_start;
    logic [15:0] amount;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        last;
    logic [14:0] readable;
    logic [14:0] writable;
  } out_word_t;

  // Controller states.
  typedef enum logic {
    CS_IDLE,
    CS_READ
  } ctl_state_t;

endpackage

`default_nettype wire

// ----- sv/prbf_ram.sv -----
// Byte ring storage: one write port and one read port, read data registered.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module prbf_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/packet_ring_byte_fifo_unit.sv -----
// Top level of the packet ring byte FIFO: pointer registers, packet staging,
// command decode and the read sequencer around the ring RAM.
// Depends on prbf_pkg and prbf_ram.
//
//   channel  ports                      direction  handshake
//   input    start, busy, in_word       in         taken when start & !busy
//   result   out_strobe, out_word       out        registered, no stall
//   config   cfg_wr_en, cfg_wr_data     in         written when cfg_wr_en
//
// Every command except a read with bytes to deliver gives its one word in the
// cycle after it is taken, and busy stays low, so a word can be taken each cycle.
// A read of n bytes holds busy while the sequencer fetches them and gives its bytes on
// consecutive cycles, through the state register and then the RAM read register.
// Reset clears pointers and the enable; the RAM is not cleared, since reads only
// reach bytes that were written. The receiver cannot stall the result words.
`timescale 1ns / 1ps
`default_nettype none

module packet_ring_byte_fifo_unit #(
  parameter int BUF_SIZE     = prbf_pkg::BUF_SIZE_DEF,
  parameter int HEADER_BYTES = prbf_pkg::HEADER_BYTES_DEF,
  parameter int MAX_READ     = prbf_pkg::MAX_READ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire prbf_pkg::in_word_t in_word,
  output logic                    out_strobe,
  output prbf_pkg::out_word_t     out_word,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data
);

  localparam int PTR_W = $clog2(BUF_SIZE);
  localparam int CMP_W = (PTR_W > 17) ? PTR_W : 17;
  localparam int SAT_W = (PTR_W > 15) ? PTR_W : 15;
  localparam int RC_W  = $clog2(MAX_READ + 1);
  localparam logic [PTR_W:0]   BUF_LEN  = (PTR_W + 1)'(BUF_SIZE);
  localparam logic [PTR_W-1:0] BUF_MAX  = PTR_W'(BUF_SIZE - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [16:0]      HDR_LEN  = 17'(HEADER_BYTES);
  localparam logic [RC_W-1:0]  READ_CAP = RC_W'(MAX_READ);

  // Advance a ring pointer by n, with n below the ring size.
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= BUF_LEN) begin
      s = s - BUF_LEN;
    end
    return s[PTR_W-1:0];
  endfunction

  prbf_pkg::ctl_state_t state_r, state_nxt;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [16:0]      rem_r, rem_nxt;
  logic             open_r, open_nxt;
  logic             en_r, en_nxt;
  logic [RC_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0] addr_r, addr_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_sel_r, out_sel_nxt;

  logic             accept;
  logic             go_read;
  logic [PTR_W-1:0] avail;
  logic [PTR_W-1:0] space;
  logic [PTR_W:0]   avail_wrap;
  logic [CMP_W-1:0] avail_ext;
  logic [CMP_W-1:0] amt_ext;
  logic [16:0]      total;
  logic [16:0]      rem_dec;
  logic [RC_W-1:0]  amt_cap;
  logic [RC_W-1:0]  rcnt;
  logic [PTR_W-1:0] skip_step;
  logic [PTR_W-1:0] fill_inc;
  logic [SAT_W-1:0] rdbl_ext;
  logic [SAT_W-1:0] wrbl_ext;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic             ram_re;
  logic [7:0]       ram_q;

  assign accept = start && !busy;
  assign busy   = (state_r == prbf_pkg::CS_READ);

  // Committed byte count and free space between the committed pointers.
  assign avail_wrap = {1'b0, wr_ptr_r} + BUF_LEN - {1'b0, rd_ptr_r};
  assign avail      = (wr_ptr_r >= rd_ptr_r) ? (wr_ptr_r - rd_ptr_r)
                                             : avail_wrap[PTR_W-1:0];
  assign space      = BUF_MAX - avail;
  assign avail_ext  = CMP_W'(avail);
  assign amt_ext    = CMP_W'(in_word.amount);

  // Packet length and staging bookkeeping.
  assign total    = HDR_LEN + {1'b0, in_word.amount};
  assign rem_dec  = (rem_r != 17'd0) ? (rem_r - 17'd1) : 17'd0;
  assign fill_inc = bump(fill_ptr_r, PTR_ONE);

  // Read and skip counts.
  assign amt_cap   = (in_word.amount > 16'(MAX_READ)) ? READ_CAP
                                                       : in_word.amount[RC_W-1:0];
  assign rcnt      = (CMP_W'(amt_cap) > avail_ext) ? RC_W'(avail) : amt_cap;
  assign skip_step = (amt_ext < avail_ext) ? amt_ext[PTR_W-1:0] : avail;

  assign go_read = accept && en_r && (in_word.command == prbf_pkg::CMD_READ)
                   && (in_word.amount != 16'd0) && (avail != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prbf_pkg::CS_IDLE: begin
        if (go_read) begin
          state_nxt = prbf_pkg::CS_READ;
        end
      end
      prbf_pkg::CS_READ: begin
        if (cnt_r == RC_W'(1)) begin
          state_nxt = prbf_pkg::CS_IDLE;
        end
      end
      default: state_nxt = prbf_pkg::CS_IDLE;
    endcase
  end

  // Command execution, RAM access and result word.
  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_ptr_nxt   = fill_ptr_r;
    rem_nxt        = rem_r;
    open_nxt       = open_r;
    en_nxt         = en_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    out_strobe_nxt = 1'b0;
    out_last_nxt   = 1'b0;
    out_status_nxt = prbf_pkg::STS_OK;
    out_sel_nxt    = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = fill_ptr_r;
    ram_re         = 1'b0;

    case (state_r)
      prbf_pkg::CS_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          if (!en_r) begin
            out_status_nxt = prbf_pkg::STS_DISABLED;
          end else begin
            case (in_word.command)
              prbf_pkg::CMD_BYTE: begin
                if (in_word.packet_start) begin
                  // A new start drops whatever was staged and is judged alone.
                  fill_ptr_nxt = wr_ptr_r;
                  open_nxt     = 1'b0;
                  rem_nxt      = 17'd0;
                  if (CMP_W'(total) > CMP_W'(space)) begin
                    out_status_nxt = prbf_pkg::STS_NO_SPACE;
                  end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_ptr_r;
                    fill_ptr_nxt = bump(wr_ptr_r, PTR_ONE);
                    rem_nxt      = total - 17'd1;
                    open_nxt     = 1'b1;
                    if (total == 17'd1) begin
                      wr_ptr_nxt = bump(wr_ptr_r, PTR_ONE);
                      open_nxt   = 1'b0;
                    end
                  end
                end else if (open_r) begin
                  ram_we       = 1'b1;
                  fill_ptr_nxt = fill_inc;
                  rem_nxt      = rem_dec;
                  if (rem_dec == 17'd0) begin
                    wr_ptr_nxt = fill_inc;
                    open_nxt   = 1'b0;
                  end
                end
              end
              prbf_pkg::CMD_READ: begin
                if (in_word.amount == 16'd0) begin
                  out_status_nxt = prbf_pkg::STS_OK;
                end else if (avail == '0) begin
                  out_status_nxt = prbf_pkg::STS_EMPTY;
                end else begin
                  // Bytes come from the sequencer; the pointer jumps to its end now.
                  out_strobe_nxt = 1'b0;
                  out_last_nxt   = 1'b0;
                  cnt_nxt        = rcnt;
                  addr_nxt       = rd_ptr_r;
                  rd_ptr_nxt     = bump(rd_ptr_r, PTR_W'(rcnt));
                end
              end
              prbf_pkg::CMD_SKIP: begin
                rd_ptr_nxt = bump(rd_ptr_r, skip_step);
              end
              prbf_pkg::CMD_FLUSH: begin
                rd_ptr_nxt = wr_ptr_r;
              end
              default: begin
                out_status_nxt = prbf_pkg::STS_OK;
              end
            endcase
          end
        end
      end
      prbf_pkg::CS_READ: begin
        // One RAM read per cycle; the byte shows up in the next cycle.
        ram_re         = 1'b1;
        addr_nxt       = bump(addr_r, PTR_ONE);
        cnt_nxt        = cnt_r - RC_W'(1);
        out_strobe_nxt = 1'b1;
        out_sel_nxt    = 1'b1;
        out_last_nxt   = (cnt_r == RC_W'(1));
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase

    // A register write clears all pointers and packet state.
    if (cfg_wr_en) begin
      en_nxt       = cfg_wr_data;
      rd_ptr_nxt   = '0;
      wr_ptr_nxt   = '0;
      fill_ptr_nxt = '0;
      rem_nxt      = 17'd0;
      open_nxt     = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prbf_pkg::CS_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      fill_ptr_r   <= '0;
      rem_r        <= 17'd0;
      open_r       <= 1'b0;
      en_r         <= 1'b0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_ptr_r   <= fill_ptr_nxt;
      rem_r        <= rem_nxt;
      open_r       <= open_nxt;
      en_r         <= en_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_sel_r    <= out_sel_nxt;
  end

  prbf_ram #(
    .DEPTH (BUF_SIZE),
    .AW    (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_word.data_byte),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_q)
  );

  // Counts shown with each word, saturated to the field width.
  assign rdbl_ext = SAT_W'(avail);
  assign wrbl_ext = SAT_W'(space);

  assign out_strobe         = out_strobe_r;
  assign out_word.status    = out_status_r;
  assign out_word.read_byte = out_sel_r ? ram_q : 8'h00;
  assign out_word.last      = out_last_r;
  assign out_word.readable  = (rdbl_ext > SAT_W'(32767)) ? 15'h7fff : rdbl_ext[14:0];
  assign out_word.writable  = (wrbl_ext > SAT_W'(32767)) ? 15'h7fff : wrbl_ext[14:0];

endmodule

`default_nettype wire

// ----- sv/prbf_checker.sv -----
// Port-level checks for the packet ring byte FIFO, bound to the top level.
// Depends on prbf_pkg and packet_ring_byte_fifo_unit.
`timescale 1ns / 1ps
`default_nettype none

module prbf_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire prbf_pkg::out_word_t out_word,
  input wire logic                out_strobe
);

  // Every word taken gives a result word in the next cycle, or after the state and RAM read registers for a read burst.
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##[1:2] out_strobe)
    else $error("no result word after an accepted word");

  // Nothing comes out unless a word was taken or a read is running.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_strobe)
    else $error("result word without a cause");

  // A result word that is not the last one belongs to a running read.
  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.last) |-> (busy && out_word.status == prbf_pkg::STS_OK))
    else $error("non-final result word outside a read");

  // Error words carry no byte.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status != prbf_pkg::STS_OK) |-> (out_word.read_byte == 8'h00))
    else $error("error word with a nonzero byte");

endmodule

bind packet_ring_byte_fifo_unit prbf_checker u_prbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_word   (out_word),
  .out_strobe (out_strobe)
);

`default_nettype wire
